[hdl/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define AM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Expression must never be true outside reset.
`define AM_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

[hdl/ffha_pkg.sv]
// Shared constants, types and helpers of the first-fit heap allocator.
package ffha_pkg;

  // Default sizing
  localparam int unsigned HEAP_BYTES_DEF   = 16384;
  localparam int unsigned PAGE_BYTES_DEF   = 4096;
  localparam int unsigned MIN_CHUNK_DEF    = 16;
  localparam int unsigned HEADER_BYTES_DEF = 4;

  // Port field widths
  localparam int unsigned FUNC_W = 1;
  localparam int unsigned SIZE_W = 15;
  localparam int unsigned ADDR_W = 14;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned USED_W = 15;

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGN = 2'd1;
  localparam logic [STAT_W-1:0] ST_OOM = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD = 2'd3;

  // Width of internal offset/size arithmetic: covers chunk + size sums,
  // grown heap sizes and the largest rounded request.
  function automatic int unsigned ffha_off_w(input int unsigned heap_b,
                                             input int unsigned page_b);
    return $clog2(3 * heap_b + page_b + 2 ** SIZE_W + 64) + 1;
  endfunction

  // Controller -> datapath commands
  typedef struct packed {
    logic              capture;
    logic              chunk_free_ld;
    logic              rd_chunk;
    logic              rd_next;
    logic              hdr_ld;
    logic              chunk_adv;
    logic              grow_init;
    logic              grow_step;
    logic              grow_commit;
    logic              wr_rem;
    logic              wr_used_split;
    logic              wr_used_whole;
    logic              wr_free;
    logic              used_add;
    logic              used_sub;
    logic              acc_add;
    logic              resp;
    logic              resp_addr;
    logic [STAT_W-1:0] resp_st;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic is_free;
    logic size_zero;
    logic addr_zero;
    logic addr_small;
    logic fchunk_oob;
    logic hdr_fit;
    logic hdr_used;
    logic hdr_sz_zero;
    logic chunk_eq_top;
    logic chunk_gt_top;
    logic grow_oob;
    logic grow_more;
    logic rem_small;
    logic next_oob;
    logic out_free;
  } sts_t;

endpackage

[hdl/ffha_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
  parameter int unsigned DATA_W = 16,
  parameter int unsigned DEPTH  = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/ffha_ctrl.sv]
// Sequencing state machine of the heap allocator.
module ffha_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ffha_pkg::sts_t sts_i,
  output ffha_pkg::cmd_t cmd_o
);
  import ffha_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_START   = 4'd1;
  localparam logic [3:0] S_ARD     = 4'd2;
  localparam logic [3:0] S_ACHK    = 4'd3;
  localparam logic [3:0] S_AADV    = 4'd4;
  localparam logic [3:0] S_AGROW   = 4'd5;
  localparam logic [3:0] S_ASPLIT  = 4'd6;
  localparam logic [3:0] S_ASPLIT2 = 4'd7;
  localparam logic [3:0] S_FRD     = 4'd8;
  localparam logic [3:0] S_FCHK    = 4'd9;
  localparam logic [3:0] S_FNXT    = 4'd10;
  localparam logic [3:0] S_FMCHK   = 4'd11;
  localparam logic [3:0] S_FWR     = 4'd12;
  localparam logic [3:0] S_RESP    = 4'd13;

  logic [3:0]        state_q, state_d;
  logic [STAT_W-1:0] st_q, st_d;
  logic              af_q, af_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    st_d    = st_q;
    af_d    = af_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_START;
        end
      end
      S_START: begin
        af_d = 1'b0;
        if (sts_i.is_free) begin
          if (sts_i.addr_zero) begin
            st_d    = ST_IGN;
            state_d = S_RESP;
          end else if (sts_i.addr_small || sts_i.fchunk_oob) begin
            st_d    = ST_BAD;
            state_d = S_RESP;
          end else begin
            cmd_o.chunk_free_ld = 1'b1;
            state_d             = S_FRD;
          end
        end else if (sts_i.size_zero) begin
          st_d    = ST_IGN;
          state_d = S_RESP;
        end else begin
          state_d = S_ARD;
        end
      end
      S_ARD: begin
        cmd_o.rd_chunk = 1'b1;
        state_d        = S_ACHK;
      end
      S_ACHK: begin
        if (sts_i.hdr_fit) begin
          cmd_o.hdr_ld = 1'b1;
          state_d      = S_ASPLIT;
        end else if (sts_i.hdr_sz_zero) begin
          st_d    = ST_BAD;
          state_d = S_RESP;
        end else begin
          cmd_o.chunk_adv = 1'b1;
          state_d         = S_AADV;
        end
      end
      S_AADV: begin
        if (sts_i.chunk_eq_top) begin
          cmd_o.grow_init = 1'b1;
          state_d         = S_AGROW;
        end else if (sts_i.chunk_gt_top) begin
          st_d    = ST_BAD;
          state_d = S_RESP;
        end else begin
          state_d = S_ARD;
        end
      end
      S_AGROW: begin
        if (sts_i.grow_oob) begin
          st_d    = ST_OOM;
          state_d = S_RESP;
        end else if (sts_i.grow_more) begin
          cmd_o.grow_step = 1'b1;
        end else begin
          cmd_o.grow_commit = 1'b1;
          state_d           = S_ARD;
        end
      end
      S_ASPLIT: begin
        if (sts_i.rem_small) begin
          cmd_o.wr_used_whole = 1'b1;
          cmd_o.used_add      = 1'b1;
          st_d                = ST_OK;
          af_d                = 1'b1;
          state_d             = S_RESP;
        end else begin
          cmd_o.wr_rem = 1'b1;
          state_d      = S_ASPLIT2;
        end
      end
      S_ASPLIT2: begin
        cmd_o.wr_used_split = 1'b1;
        cmd_o.used_add      = 1'b1;
        st_d                = ST_OK;
        af_d                = 1'b1;
        state_d             = S_RESP;
      end
      S_FRD: begin
        cmd_o.rd_chunk = 1'b1;
        state_d        = S_FCHK;
      end
      S_FCHK: begin
        if (sts_i.hdr_sz_zero) begin
          st_d    = ST_BAD;
          state_d = S_RESP;
        end else begin
          cmd_o.hdr_ld   = 1'b1;
          cmd_o.used_sub = 1'b1;
          state_d        = S_FNXT;
        end
      end
      S_FNXT: begin
        if (sts_i.next_oob) begin
          state_d = S_FWR;
        end else begin
          cmd_o.rd_next = 1'b1;
          state_d       = S_FMCHK;
        end
      end
      S_FMCHK: begin
        if (sts_i.hdr_used || sts_i.hdr_sz_zero) begin
          state_d = S_FWR;
        end else begin
          cmd_o.acc_add = 1'b1;
          state_d       = S_FNXT;
        end
      end
      S_FWR: begin
        cmd_o.wr_free = 1'b1;
        st_d          = ST_OK;
        state_d       = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.resp      = 1'b1;
          cmd_o.resp_addr = af_q;
          cmd_o.resp_st   = st_q;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
      af_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      af_q    <= af_d;
    end
  end

endmodule

[hdl/ffha_dp.sv]
// Datapath: request registers, chunk walk arithmetic, header RAM, result register.
module ffha_dp #(
  parameter int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned PAGE_BYTES   = ffha_pkg::PAGE_BYTES_DEF,
  parameter int unsigned MIN_CHUNK    = ffha_pkg::MIN_CHUNK_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [ffha_pkg::FUNC_W-1:0]  func_i,
  input  logic [ffha_pkg::SIZE_W-1:0]  size_i,
  input  logic [ffha_pkg::ADDR_W-1:0]  addr_i,
  input  logic                         out_ready_i,
  input  ffha_pkg::cmd_t               cmd_i,
  output ffha_pkg::sts_t               sts_o,
  output logic                         out_valid_o,
  output logic [ffha_pkg::ADDR_W-1:0]  result_addr_o,
  output logic [ffha_pkg::STAT_W-1:0]  status_o,
  output logic [ffha_pkg::USED_W-1:0]  used_bytes_o
);
  import ffha_pkg::*;

  localparam int unsigned AW   = $clog2(HEAP_BYTES);
  localparam int unsigned SZ_W = AW + 1;
  localparam int unsigned HW   = SZ_W + 1;
  localparam int unsigned OW   = ffha_off_w(HEAP_BYTES, PAGE_BYTES);
  localparam int unsigned UW   = ((OW > USED_W) ? OW : USED_W) + 1;

  localparam logic [OW-1:0]     HEAP_O   = OW'(HEAP_BYTES);
  localparam logic [OW-1:0]     PAGE_O   = OW'(PAGE_BYTES);
  localparam logic [OW-1:0]     MIN_O    = OW'(MIN_CHUNK);
  localparam logic [OW-1:0]     HDR_O    = OW'(HEADER_BYTES);
  localparam logic [USED_W-1:0] USED_MAX = {USED_W{1'b1}};

  // request and walk registers
  logic [FUNC_W-1:0] func_q;
  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] addr_q;
  logic [OW-1:0]     realsize_q;
  logic [OW-1:0]     chunk_q;
  logic [OW-1:0]     grow_q;
  logic [OW-1:0]     hsize_q;
  logic [OW-1:0]     acc_q;
  logic [OW-1:0]     top_q;
  logic [USED_W-1:0] used_q, used_d;
  logic              init0_q;  // offset 0 still holds its reset header
  logic              rd0_q;    // last read hit the unwritten offset 0

  // result register
  logic              out_valid_q;
  logic [ADDR_W-1:0] res_addr_q;
  logic [STAT_W-1:0] status_q;
  logic [USED_W-1:0] used_out_q;

  // RAM interface
  logic          ram_we;
  logic [OW-1:0] waddr;
  logic [OW-1:0] wsize;
  logic          wused;
  logic          wr_req;
  logic [OW-1:0] raddr;
  logic          ram_re;
  logic [HW-1:0] rdata;
  logic [HW-1:0] wdata;

  logic [OW-1:0] rs_sum;
  logic [OW-1:0] rs;
  logic [OW-1:0] hdr_size;
  logic          hdr_used;
  logic [OW-1:0] fchunk;
  logic [OW-1:0] next_off;
  logic [UW-1:0] used_sum;

  // rounded request at capture
  assign rs_sum = OW'(size_i) + HDR_O;
  assign rs     = (rs_sum < MIN_O) ? MIN_O : rs_sum;

  // header decode, offset 0 reads its reset value until first written
  assign hdr_used = rd0_q ? 1'b0 : rdata[HW-1];
  assign hdr_size = rd0_q ? PAGE_O : OW'(rdata[SZ_W-1:0]);

  assign fchunk   = OW'(addr_q) - HDR_O;
  assign next_off = chunk_q + acc_q;

  // write port select, one write per cycle
  always_comb begin
    wr_req = 1'b1;
    waddr  = chunk_q;
    wsize  = acc_q;
    wused  = 1'b0;
    if (cmd_i.grow_commit) begin
      waddr = top_q;
      wsize = grow_q;
    end else if (cmd_i.wr_rem) begin
      waddr = chunk_q + realsize_q;
      wsize = hsize_q - realsize_q;
    end else if (cmd_i.wr_used_split) begin
      wsize = realsize_q;
      wused = 1'b1;
    end else if (cmd_i.wr_used_whole) begin
      wsize = hsize_q;
      wused = 1'b1;
    end else if (cmd_i.wr_free) begin
      wsize = acc_q;
    end else begin
      wr_req = 1'b0;
    end
  end

  // writes beyond the store are dropped
  assign ram_we = wr_req && (waddr < HEAP_O);
  assign wdata  = {wused, wsize[SZ_W-1:0]};
  assign raddr  = cmd_i.rd_next ? next_off : chunk_q;
  assign ram_re = cmd_i.rd_chunk || cmd_i.rd_next;

  ffha_ram #(
    .DATA_W(HW),
    .DEPTH (HEAP_BYTES)
  ) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr[AW-1:0]),
    .wdata_i(wdata),
    .re_i   (ram_re),
    .raddr_i(raddr[AW-1:0]),
    .rdata_o(rdata)
  );

  // saturating used-byte accounting
  assign used_sum = UW'(used_q) + UW'(realsize_q);
  always_comb begin
    used_d = used_q;
    if (cmd_i.used_add) begin
      used_d = (used_sum > UW'(USED_MAX)) ? USED_MAX : used_sum[USED_W-1:0];
    end else if (cmd_i.used_sub) begin
      if (UW'(used_q) < UW'(hdr_size)) begin
        used_d = '0;
      end else begin
        used_d = used_q - hdr_size[USED_W-1:0];
      end
    end
  end

  // status to the controller
  always_comb begin
    sts_o              = '0;
    sts_o.is_free      = (func_q == FUNC_FREE);
    sts_o.size_zero    = (size_q == '0);
    sts_o.addr_zero    = (addr_q == '0);
    sts_o.addr_small   = (OW'(addr_q) < HDR_O);
    sts_o.fchunk_oob   = (fchunk >= top_q) || (fchunk >= HEAP_O);
    sts_o.hdr_fit      = !hdr_used && (hdr_size >= realsize_q);
    sts_o.hdr_used     = hdr_used;
    sts_o.hdr_sz_zero  = (hdr_size == '0);
    sts_o.chunk_eq_top = (chunk_q == top_q);
    sts_o.chunk_gt_top = (chunk_q > top_q);
    sts_o.grow_oob     = ((top_q + grow_q) > HEAP_O);
    sts_o.grow_more    = (grow_q <= realsize_q);
    sts_o.rem_small    = ((hsize_q - realsize_q) < MIN_O);
    sts_o.next_oob     = (next_off >= top_q);
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q     <= func_i;
      size_q     <= size_i;
      addr_q     <= addr_i;
      realsize_q <= rs;
      chunk_q    <= '0;
    end else if (cmd_i.chunk_free_ld) begin
      chunk_q <= fchunk;
    end else if (cmd_i.chunk_adv) begin
      chunk_q <= chunk_q + hdr_size;
    end
    if (cmd_i.grow_init) begin
      grow_q <= PAGE_O;
    end else if (cmd_i.grow_step) begin
      grow_q <= grow_q + PAGE_O;
    end
    if (cmd_i.hdr_ld) begin
      hsize_q <= hdr_size;
      acc_q   <= hdr_size;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + hdr_size;
    end
    if (cmd_i.resp) begin
      res_addr_q <= cmd_i.resp_addr ? ADDR_W'(chunk_q + HDR_O) : '0;
      status_q   <= cmd_i.resp_st;
      used_out_q <= used_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= PAGE_O;
      used_q      <= '0;
      init0_q     <= 1'b1;
      rd0_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      used_q <= used_d;
      if (cmd_i.grow_commit) begin
        top_q <= top_q + grow_q;
      end
      if (ram_we && (waddr == '0)) begin
        init0_q <= 1'b0;
      end
      if (ram_re) begin
        rd0_q <= (raddr == '0) && init0_q;
      end
      if (cmd_i.resp) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_addr_o = res_addr_q;
  assign status_o      = status_q;
  assign used_bytes_o  = used_out_q;

endmodule

[hdl/first_fit_heap_allocator.sv]
// Top level of the first-fit heap allocator: controller, datapath and header RAM.
//
//   beat     | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------------------------
//   request  | in        | in_valid_i / in_ready_o   | func_i, size_i, addr_i
//   result   | out       | out_valid_o / out_ready_i | result_addr_o, status_o, used_bytes_o
//
// Flow: one request at a time. An allocate walks the chunk chain from offset 0 and
//   steps over each chunk that does not fit with a header read, a check and an
//   advance; at the heap top it grows the heap page by page. A free reads its
//   chunk's header, then one header per following free chunk that it merges. The
//   chain walk through the header RAM's single read port dominates the time taken.
// Reset: control state, heap top and byte count clear at once; the header RAM is
//   not cleared, the first chunk's header is supplied by a flag until rewritten.
// Stalls: the result sits in an output register; a new request is accepted while
//   it waits, and the next result holds in the controller until the register frees.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned PAGE_BYTES   = ffha_pkg::PAGE_BYTES_DEF,
  parameter int unsigned MIN_CHUNK    = ffha_pkg::MIN_CHUNK_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request beat
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ffha_pkg::FUNC_W-1:0] func_i,
  input  logic [ffha_pkg::SIZE_W-1:0] size_i,
  input  logic [ffha_pkg::ADDR_W-1:0] addr_i,
  // result beat
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ffha_pkg::ADDR_W-1:0] result_addr_o,
  output logic [ffha_pkg::STAT_W-1:0] status_o,
  output logic [ffha_pkg::USED_W-1:0] used_bytes_o
);
  import ffha_pkg::*;

  // command and status bundles between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // Sequencer: decodes the request, steps the chunk walk, the heap growth,
  // the split and the merge, and hands the result to the output register.
  ffha_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Datapath: holds the heap top, byte count, walk offsets and the header RAM.
  ffha_dp #(
    .HEAP_BYTES  (HEAP_BYTES),
    .PAGE_BYTES  (PAGE_BYTES),
    .MIN_CHUNK   (MIN_CHUNK),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .func_i       (func_i),
    .size_i       (size_i),
    .addr_i       (addr_i),
    .out_ready_i  (out_ready_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .result_addr_o(result_addr_o),
    .status_o     (status_o),
    .used_bytes_o (used_bytes_o)
  );

endmodule

[hdl/ffha_checker.sv]
// Port-level checker of the heap allocator and its bind.
`include "assert_macros.svh"

module ffha_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [ffha_pkg::ADDR_W-1:0] result_addr_o,
  input logic [ffha_pkg::STAT_W-1:0] status_o,
  input logic [ffha_pkg::USED_W-1:0] used_bytes_o
);
  import ffha_pkg::*;

  // a stalled result beat stays put
  `AM_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(result_addr_o) && $stable(status_o) && $stable(used_bytes_o)), "result beat changed while stalled")

  // only a successful allocate carries an address
  `AM_NEVER(a_addr_only_ok, clk_i, rst_ni, out_valid_o && (status_o != ST_OK) && (result_addr_o != '0), "address returned with failure status")

  // one request in flight: accepting a beat drops ready on the next cycle
  `AM_ASSERT(a_one_in_flight, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "second request taken while busy")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .result_addr_o(result_addr_o),
  .status_o     (status_o),
  .used_bytes_o (used_bytes_o)
);

[dv/tb_first_fit_heap_allocator.sv]
// Self-checking testbench for the first-fit heap allocator.
module tb_first_fit_heap_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import ffha_pkg::*;

  localparam int HEAP   = HEAP_BYTES_DEF;
  localparam int PAGE   = PAGE_BYTES_DEF;
  localparam int MINCH  = MIN_CHUNK_DEF;
  localparam int HDR    = HEADER_BYTES_DEF;
  localparam int USED_SAT     = 32767;
  localparam int RAND_ITEMS   = 850;
  localparam int CALM_FROM    = 300;   // no stalls on either side in this window
  localparam int CALM_TO      = 420;
  localparam int IDLE_PCT     = 30;
  localparam int DRAIN_CYCLES = 64;
  // Hang guard: far above a fully fragmented heap walked on every request.
  localparam int CYCLE_LIMIT  = 12_000_000;

  typedef struct packed {
    logic              used;
    logic [USED_W-1:0] size;
  } chunk_hdr_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
  } heap_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [STAT_W-1:0] st;
    logic [USED_W-1:0] used;
  } heap_result_t;

  // DUT signals; the ones the bench drives are known from time zero
  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [FUNC_W-1:0] func       = FUNC_ALLOC;
  logic [SIZE_W-1:0] size       = '0;
  logic [ADDR_W-1:0] addr       = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [ADDR_W-1:0] result_addr;
  logic [STAT_W-1:0] status;
  logic [USED_W-1:0] used_bytes;

  // Shadow heap: headers, top of heap, byte count
  chunk_hdr_t   hdr_mem  [HEAP];
  bit           hdr_seen [HEAP];
  int           heap_end;
  int           bytes_in_use;
  int           live_q [$];      // payloads handed out and not yet freed
  int           seen_q [$];      // every header offset ever written

  heap_req_t    req_q [$];       // beats waiting for the driver
  heap_req_t    drv_req;
  bit           req_busy = 1'b0; // a beat is on the port and not yet taken
  heap_result_t result_due_q [$];
  heap_result_t got;

  int  err_cnt  = 0;
  int  cyc_cnt  = 0;
  int  real_cnt = 0;
  wire calm = (real_cnt >= CALM_FROM) && (real_cnt < CALM_TO);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  first_fit_heap_allocator uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (func),
    .size_i        (size),
    .addr_i        (addr),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .result_addr_o (result_addr),
    .status_o      (status),
    .used_bytes_o  (used_bytes)
  );

  // ---------------------------------------------------------------- shadow heap
  function automatic chunk_hdr_t hdr_rd(int off);
    chunk_hdr_t h;
    h = '0;
    if (off < HEAP) h = hdr_mem[off];
    return h;
  endfunction

  function automatic void hdr_wr(int off, int sz, logic used);
    if (off >= HEAP) return;
    hdr_mem[off].used = used;
    hdr_mem[off].size = sz[USED_W-1:0];
    if (!hdr_seen[off]) begin
      hdr_seen[off] = 1'b1;
      seen_q.push_back(off);
    end
  endfunction

  function automatic heap_result_t pack_result(int a, logic [STAT_W-1:0] st);
    heap_result_t r;
    r.addr = a[ADDR_W-1:0];
    r.st   = st;
    r.used = bytes_in_use[USED_W-1:0];
    return r;
  endfunction

  // Applies one request to the shadow heap and returns the beat it must produce.
  function automatic heap_result_t heap_apply(logic [FUNC_W-1:0] fn,
                                              logic [SIZE_W-1:0] sz_in,
                                              logic [ADDR_W-1:0] ad_in);
    chunk_hdr_t h;
    int need;
    int chunk;
    int csz;
    int grow;
    int remain;
    int nxt;
    if (fn == FUNC_ALLOC) begin
      if (sz_in == 0) return pack_result(0, ST_IGN);
      need = HDR + int'(sz_in);
      if (need < MINCH) need = MINCH;
      chunk = 0;
      // first fit: walk the chain, grow the heap when the walk hits the top
      forever begin
        h = hdr_rd(chunk);
        if (!h.used && int'(h.size) >= need) break;
        csz = int'(h.size);
        if (csz == 0) return pack_result(0, ST_BAD);
        chunk += csz;
        if (chunk == heap_end) begin
          grow = (need / PAGE + 1) * PAGE;
          if (heap_end + grow > HEAP) return pack_result(0, ST_OOM);
          hdr_wr(heap_end, grow, 1'b0);
          heap_end += grow;
        end else if (chunk > heap_end) begin
          return pack_result(0, ST_BAD);
        end
      end
      h      = hdr_rd(chunk);
      csz    = int'(h.size);
      remain = csz - need;
      if (remain < MINCH) begin
        hdr_wr(chunk, csz, 1'b1);
      end else begin
        hdr_wr(chunk + need, remain, 1'b0);
        hdr_wr(chunk, need, 1'b1);
      end
      bytes_in_use = (bytes_in_use + need > USED_SAT) ? USED_SAT : bytes_in_use + need;
      live_q.push_back(chunk + HDR);
      return pack_result(chunk + HDR, ST_OK);
    end
    // free
    if (ad_in == 0) return pack_result(0, ST_IGN);
    if (int'(ad_in) < HDR) return pack_result(0, ST_BAD);
    chunk = int'(ad_in) - HDR;
    if (chunk >= heap_end || chunk >= HEAP) return pack_result(0, ST_BAD);
    h   = hdr_rd(chunk);
    csz = int'(h.size);
    if (csz == 0) return pack_result(0, ST_BAD);
    bytes_in_use = (bytes_in_use < csz) ? 0 : bytes_in_use - csz;
    // absorb the free chunks that follow, below the top
    forever begin
      nxt = chunk + csz;
      if (nxt >= heap_end) break;
      h = hdr_rd(nxt);
      if (h.used || h.size == 0) break;
      csz += int'(h.size);
    end
    hdr_wr(chunk, csz, 1'b0);
    foreach (live_q[i]) begin
      if (live_q[i] == chunk + HDR) begin
        live_q.delete(i);
        break;
      end
    end
    return pack_result(0, ST_OK);
  endfunction

  // ---------------------------------------------------------------- driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (!req_busy) begin
        if (req_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          drv_req  = req_q.pop_front();
          func     <= drv_req.func;
          size     <= drv_req.size;
          addr     <= drv_req.addr;
          in_valid <= 1'b1;
          req_busy = 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("[first_fit_heap_allocator] ERROR");
      $finish;
    end
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (result_due_q.size() == 0) begin
          $error("result beat with nothing expected: addr %0d status %0d used %0d",
                 result_addr, status, used_bytes);
          err_cnt++;
        end else begin
          got = result_due_q.pop_front();
          if (result_addr !== got.addr) begin
            $error("result_addr: expected %0d, got %0d", got.addr, result_addr);
            err_cnt++;
          end
          if (status !== got.st) begin
            $error("status: expected %0d, got %0d", got.st, status);
            err_cnt++;
          end
          if (used_bytes !== got.used) begin
            $error("used_bytes: expected %0d, got %0d", got.used, used_bytes);
            err_cnt++;
          end
        end
      end
      // request taken: predict, then free the slot for the next decision
      if (in_valid && in_ready) begin
        result_due_q.push_back(heap_apply(func, size, addr));
        req_busy = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  // Next request is chosen only once the previous one is taken, so the
  // shadow heap is current when free offsets are picked.
  task automatic wait_slot();
    wait (req_q.size() == 0 && !req_busy);
  endtask

  task automatic queue_req(logic [FUNC_W-1:0] fn, int sz, int ad);
    heap_req_t r;
    wait_slot();
    r.func = fn;
    r.size = sz[SIZE_W-1:0];
    r.addr = ad[ADDR_W-1:0];
    req_q.push_back(r);
  endtask

  function automatic int pick_alloc_size();
    int r;
    r = $urandom_range(99);
    if (r < 3)  return ($urandom_range(1) != 0) ? 16384 : $urandom_range(16384, 8001);
    if (r < 10) return $urandom_range(8000, 1001);
    if (r < 30) return $urandom_range(1000, 61);
    return $urandom_range(60, 1);
  endfunction

  initial begin
    heap_req_t r;
    int        pick;
    int        free_pct;
    // one free page at offset 0 after reset
    hdr_wr(0, PAGE, 1'b0);
    heap_end     = PAGE;
    bytes_in_use = 0;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed: null and bad requests, rounding, growth, OOM, split/whole, merges
    queue_req(FUNC_ALLOC, 0, 0);        // zero request
    queue_req(FUNC_FREE, 0, 0);         // null free
    queue_req(FUNC_FREE, 0, 1);         // below header size
    queue_req(FUNC_FREE, 0, 3);
    queue_req(FUNC_FREE, 0, 16383);     // beyond heap top
    queue_req(FUNC_ALLOC, 1, 0);        // rounded up to min chunk
    queue_req(FUNC_ALLOC, 12, 0);       // exactly min chunk
    queue_req(FUNC_ALLOC, 13, 0);       // one above min chunk
    queue_req(FUNC_ALLOC, 16384, 0);    // growth would overflow the heap
    queue_req(FUNC_ALLOC, 5000, 0);     // two-page growth, then split
    queue_req(FUNC_ALLOC, 4090, 0);     // growth to exactly full, taken whole
    queue_req(FUNC_ALLOC, 16384, 0);    // heap full
    queue_req(FUNC_FREE, 0, 20);        // next chunk used, no merge
    queue_req(FUNC_FREE, 0, 20);        // double free, size subtracted again
    queue_req(FUNC_FREE, 0, 4);         // merges with the freed neighbor
    queue_req(FUNC_ALLOC, 8, 0);        // split of the merged chunk
    queue_req(FUNC_ALLOC, 9, 0);        // exact fit
    queue_req(FUNC_FREE, 0, 4100);      // merge stops at a used header
    queue_req(FUNC_FREE, 0, 12292);     // last chunk, merge stops at top
    queue_req(FUNC_FREE, 0, 36);        // long merge up to the top
    queue_req(FUNC_FREE, 0, 4);
    queue_req(FUNC_FREE, 0, 20);

    // random: mostly alloc/free of live chunks, some stale and noise beats
    while (real_cnt < RAND_ITEMS) begin
      wait_slot();
      pick     = $urandom_range(99);
      free_pct = (live_q.size() > 48) ? 65 : 45;
      r.size   = '0;
      r.addr   = '0;
      if (pick < 4) begin
        case ($urandom_range(3))
          0: r.func = FUNC_ALLOC;
          1: r.func = FUNC_FREE;
          2: begin
            r.func = FUNC_FREE;
            r.addr = ADDR_W'($urandom_range(HDR - 1, 1));
          end
          default: begin
            r.func = FUNC_FREE;
            if (heap_end + HDR <= HEAP - 1)
              r.addr = ADDR_W'($urandom_range(HEAP - 1, heap_end + HDR));
            else
              r.addr = ADDR_W'($urandom_range(HDR - 1, 1));
          end
        endcase
      end else if (pick < 9) begin
        // stale or double free of any header ever written
        r.func = FUNC_FREE;
        r.addr = ADDR_W'(seen_q[$urandom_range(seen_q.size() - 1)] + HDR);
      end else if (pick < free_pct && live_q.size() != 0) begin
        r.func = FUNC_FREE;
        r.addr = ADDR_W'(live_q[$urandom_range(live_q.size() - 1)]);
      end else begin
        r.func = FUNC_ALLOC;
        r.size = SIZE_W'(pick_alloc_size());
      end
      // ignored beats do not count toward the random total
      if (!((r.func == FUNC_ALLOC && r.size == 0) || (r.func == FUNC_FREE && r.addr == 0)))
        real_cnt++;
      req_q.push_back(r);
    end

    // all taken, all answered, then a quiet tail
    wait_slot();
    wait (result_due_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[first_fit_heap_allocator] OK");
    end else begin
      $display("[first_fit_heap_allocator] ERROR");
    end
    $finish;
  end

endmodule
